// ----- rtl/core/scts_pkg.sv -----
// Package for the sorted code table search block.
// Field widths, item mode codes and the code remap shared by the RTL.
// No dependencies.
package scts_pkg;

    localparam int CODE_W  = 21;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;

    // Item mode codes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // Legacy code 128 stands for the euro sign
    localparam logic [CODE_W-1:0] REMAP_FROM = CODE_W'(128);
    localparam logic [CODE_W-1:0] REMAP_TO   = CODE_W'(32'h20AC);

    function automatic logic [CODE_W-1:0] remap_code(input logic [CODE_W-1:0] code);
        remap_code = (code == REMAP_FROM) ? REMAP_TO : code;
    endfunction

endpackage

// ----- rtl/core/sorted_code_table_search.sv -----
// Sorted code table search: code table memory plus binary search sequencer.
// Lookup: the accepting edge issues the first read (none if the table is empty),
// then the search state does one table read per halving step and the check state
// compares the last entry read and loads the result register, holding while it is
// still full. Next request taken once back in idle; writes leave the sequencer idle.
// Sync active-low reset clears control, entry_count; table undefined. Uses scts_pkg.
module sorted_code_table_search
    import scts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Item request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [CODE_W-1:0]  i_code_point,
    // Result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [SLOT_W-1:0]  o_match_index,
    // entry_count write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam logic [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK
    } t_state;

    t_state             r_state;
    logic [COUNT_W-1:0] r_count;
    logic [CODE_W-1:0]  r_code;
    logic [SW-1:0]      r_lo;
    logic [SW-1:0]      r_hi;
    logic [SW-1:0]      r_mid;
    logic               r_empty;
    logic               r_out_valid;
    logic               r_found;
    logic [SLOT_W-1:0]  r_match_index;

    logic [CODE_W-1:0]  r_table [TABLE_DEPTH];
    logic [CODE_W-1:0]  r_rdata;

    logic               in_acc;
    logic               is_lookup;
    logic [SW-1:0]      count_s;
    logic [SW-1:0]      n_eff;
    logic [SW-1:0]      slot_s;
    logic               slot_ok;
    logic [SW-1:0]      start_mid;
    logic               start_more;
    logic               le;
    logic [SW-1:0]      step_lo;
    logic [SW-1:0]      step_hi;
    logic [SW-1:0]      step_mid;
    logic               step_more;
    logic               hit;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_index = r_match_index;

    assign in_acc    = i_in_valid && o_in_ready;
    assign is_lookup = (i_mode == MODE_LOOKUP);

    // Count saturates at the table depth
    assign count_s = SW'(r_count);
    assign n_eff   = (count_s > DEPTH_S) ? DEPTH_S : count_s;
    assign slot_s  = SW'(i_slot);
    assign slot_ok = (slot_s < DEPTH_S);

    // First probe: lo = 0, hi = n
    assign start_mid  = n_eff >> 1;
    assign start_more = (n_eff > SW'(1));

    // One halving step on the entry read last cycle
    assign le        = (r_rdata <= r_code);
    assign step_lo   = le ? r_mid : r_lo;
    assign step_hi   = le ? r_hi : r_mid;
    assign step_mid  = step_lo + ((step_hi - step_lo) >> 1);
    assign step_more = ((step_lo + SW'(1)) < step_hi);

    assign hit = !r_empty && (r_rdata == r_code);

    // Memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = slot_s[AW-1:0];
        if (r_state == ST_IDLE && in_acc) begin
            if (is_lookup) begin
                rd_en   = (n_eff != '0);
                rd_addr = start_more ? start_mid[AW-1:0] : '0;
            end else begin
                wr_en = slot_ok;
            end
        end else if (r_state == ST_SEARCH) begin
            rd_en   = 1'b1;
            rd_addr = step_more ? step_mid[AW-1:0] : step_lo[AW-1:0];
        end
    end

    // Code table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= i_code_point;
        end
        if (rd_en) begin
            r_rdata <= r_table[rd_addr];
        end
    end

    // entry_count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    // Search sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // the check state refills the result register itself
            if (r_out_valid && i_out_ready && r_state != ST_CHECK) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && is_lookup) begin
                        r_code  <= remap_code(i_code_point);
                        r_lo    <= '0;
                        r_hi    <= n_eff;
                        r_mid   <= start_mid;
                        r_empty <= (n_eff == '0);
                        r_state <= start_more ? ST_SEARCH : ST_CHECK;
                    end
                end
                ST_SEARCH: begin
                    r_lo  <= step_lo;
                    r_hi  <= step_hi;
                    r_mid <= step_mid;
                    if (!step_more) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    // hold until the result register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_found       <= hit;
                        r_match_index <= hit ? r_lo[SLOT_W-1:0] : '0;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Search window stays open while halving
    a_window_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> ((r_lo + SW'(1)) < r_hi))
        else $error("search window collapsed while searching");

    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_hi <= n_eff))
        else $error("search upper bound beyond entry count");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_match_index == '0))
        else $error("miss result carries a nonzero index");

    a_empty_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_lookup && n_eff == '0) |=> (r_state == ST_CHECK && r_empty))
        else $error("empty table lookup did not go straight to check");

    a_check_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && !r_out_valid) |=> (r_state == ST_IDLE && r_out_valid))
        else $error("check stalled with a free result register");

endmodule
